FILE: rtl/yawpc_pkg.sv
// Shared types, constants and fixed-point helpers for the yaw/pitch camera block.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package yawpc_pkg;

  localparam int ANG_W   = 25;
  localparam int PITCH_W = 24;
  localparam int DELTA_W = 16;
  localparam int SENS_W  = 16;
  localparam int COMP_W  = 16;
  localparam int Q30_W   = 32;
  localparam int Z_W     = 26;
  localparam int SUM_W   = 35;
  localparam int RED_W   = 34;

  localparam int YAW_HALF     = 11796480;
  localparam int YAW_TURN     = 23592960;
  localparam int QUARTER_TURN = 5898240;
  localparam int PITCH_LIMIT  = 5832704;
  localparam int BIAS_TURNS   = 128;
  localparam int RED_STEPS    = 9;
  localparam int RED_CNT_W    = $clog2(RED_STEPS);

  localparam logic signed [SUM_W-1:0] YAW_BIAS =
    SUM_W'(longint'(YAW_HALF) + longint'(BIAS_TURNS) * longint'(YAW_TURN));

  localparam logic [SENS_W-1:0]        SENS_RESET = 16'd6554;
  localparam logic signed [ANG_W-1:0]  YAW_RESET  = ANG_W'(-QUARTER_TURN);

  localparam int GAIN_Q30   = 652032874;
  localparam int ATAN_N     = 30;
  localparam int ATAN_IDX_W = 5;
  localparam int ATAN_W     = 22;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);

  localparam int MUL_N = 4;
  localparam int MUL_CNT_W = $clog2(MUL_N + 1);

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_SUM,
    F_RED,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROT,
    B_MUL,
    B_OUT
  } back_state_e;

  typedef struct packed {
    logic signed [ANG_W-1:0]   yaw;
    logic signed [PITCH_W-1:0] pitch;
  } angles_t;

  typedef struct packed {
    logic signed [ANG_W-1:0]   yaw_angle;
    logic signed [PITCH_W-1:0] pitch_angle;
    logic signed [COMP_W-1:0]  view_x;
    logic signed [COMP_W-1:0]  view_y;
    logic signed [COMP_W-1:0]  view_z;
    logic signed [COMP_W-1:0]  right_x;
    logic signed [COMP_W-1:0]  right_y;
    logic signed [COMP_W-1:0]  right_z;
    logic signed [COMP_W-1:0]  up_x;
    logic signed [COMP_W-1:0]  up_y;
    logic signed [COMP_W-1:0]  up_z;
  } result_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    begin
      unique case (idx)
        5'd0:  v = 22'd2949120;
        5'd1:  v = 22'd1740967;
        5'd2:  v = 22'd919879;
        5'd3:  v = 22'd466945;
        5'd4:  v = 22'd234379;
        5'd5:  v = 22'd117304;
        5'd6:  v = 22'd58666;
        5'd7:  v = 22'd29335;
        5'd8:  v = 22'd14668;
        5'd9:  v = 22'd7334;
        5'd10: v = 22'd3667;
        5'd11: v = 22'd1833;
        5'd12: v = 22'd917;
        5'd13: v = 22'd458;
        5'd14: v = 22'd229;
        5'd15: v = 22'd115;
        5'd16: v = 22'd57;
        5'd17: v = 22'd29;
        5'd18: v = 22'd14;
        5'd19: v = 22'd7;
        5'd20: v = 22'd4;
        5'd21: v = 22'd2;
        5'd22: v = 22'd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // Q2.30 -> Q1.15, round half up, saturate
  function automatic logic signed [COMP_W-1:0] q30_to_q15(input logic signed [Q30_W-1:0] v);
    logic signed [Q30_W:0] t;
    logic signed [17:0]    s;
    begin
      t = $signed({v[Q30_W-1], v}) + 33'sd16384;
      s = 18'(t >>> 15);
      if (s > 18'sd32767) return 16'sd32767;
      if (s < -18'sd32768) return -16'sd32768;
      return 16'(s);
    end
  endfunction

  // Q4.60 product -> Q1.15, round half up, saturate
  function automatic logic signed [COMP_W-1:0] prod_to_q15(input logic signed [63:0] v);
    logic signed [63:0] t;
    logic signed [18:0] s;
    begin
      t = v + (64'sd1 <<< 44);
      s = 19'(t >>> 45);
      if (s > 19'sd32767) return 16'sd32767;
      if (s < -19'sd32768) return -16'sd32768;
      return 16'(s);
    end
  endfunction

endpackage

FILE: rtl/yawpc_front.sv
// Front end: takes mouse words, scales deltas, wraps yaw and clamps pitch.
// Holds the yaw/pitch accumulators and pushes angle pairs to the queue. Uses yawpc_pkg.
`timescale 1ns / 1ps

module yawpc_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [yawpc_pkg::DELTA_W-1:0] delta_x_i,
  input  logic signed [yawpc_pkg::DELTA_W-1:0] delta_y_i,
  input  logic [yawpc_pkg::SENS_W-1:0]    sens_i,
  output logic                            push_o,
  output yawpc_pkg::angles_t              push_data_o,
  input  logic                            full_i
);
  import yawpc_pkg::*;

  localparam logic [RED_W-1:0]        TURN_R    = RED_W'(YAW_TURN);
  localparam logic [ANG_W-1:0]        HALF_A    = ANG_W'(YAW_HALF);
  localparam logic signed [SUM_W-1:0] PITCH_MAX = SUM_W'(PITCH_LIMIT);
  localparam logic signed [SUM_W-1:0] PITCH_MIN = SUM_W'(-PITCH_LIMIT);

  front_state_e state_q, state_d;

  logic signed [DELTA_W-1:0]     dx_q, dy_q;
  logic signed [DELTA_W+SENS_W:0] prod_x_q, prod_y_q;
  logic signed [DELTA_W+SENS_W:0] prod_x_d, prod_y_d;
  logic [RED_W-1:0]              u_q;
  logic [RED_CNT_W-1:0]          red_cnt_q;
  logic signed [ANG_W-1:0]       yaw_q;
  logic signed [PITCH_W-1:0]     pitch_q;

  logic signed [SUM_W-1:0] yaw_sum, pitch_sum;
  logic signed [PITCH_W-1:0] pitch_clamp;
  logic [RED_W-1:0] sub_val, red_val;
  logic accept, push;

  assign prod_x_d = dx_q * $signed({1'b0, sens_i});
  assign prod_y_d = dy_q * $signed({1'b0, sens_i});

  assign yaw_sum = $signed({{(SUM_W-ANG_W){yaw_q[ANG_W-1]}}, yaw_q})
                 + $signed({{(SUM_W-DELTA_W-SENS_W-1){prod_x_q[DELTA_W+SENS_W]}}, prod_x_q})
                 + YAW_BIAS;

  assign pitch_sum = $signed({{(SUM_W-PITCH_W){pitch_q[PITCH_W-1]}}, pitch_q})
                   + $signed({{(SUM_W-DELTA_W-SENS_W-1){prod_y_q[DELTA_W+SENS_W]}}, prod_y_q});

  always_comb begin
    if (pitch_sum > PITCH_MAX) begin
      pitch_clamp = PITCH_W'(PITCH_MAX);
    end else if (pitch_sum < PITCH_MIN) begin
      pitch_clamp = PITCH_W'(PITCH_MIN);
    end else begin
      pitch_clamp = PITCH_W'(pitch_sum);
    end
  end

  assign sub_val = TURN_R << red_cnt_q;
  assign red_val = (u_q >= sub_val) ? (u_q - sub_val) : u_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (in_valid_i) state_d = F_MUL;
      F_MUL:   state_d = F_SUM;
      F_SUM:   state_d = F_RED;
      F_RED:   if (red_cnt_q == '0) state_d = F_PUSH;
      F_PUSH:  if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    push       = 1'b0;
    unique case (state_q)
      F_IDLE:  in_stall_o = 1'b0;
      F_PUSH:  push = !full_i;
      default: ;
    endcase
  end

  assign accept            = in_valid_i && !in_stall_o;
  assign push_o            = push;
  assign push_data_o.yaw   = yaw_q;
  assign push_data_o.pitch = pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      yaw_q     <= YAW_RESET;
      pitch_q   <= '0;
      red_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_SUM) begin
        pitch_q   <= pitch_clamp;
        red_cnt_q <= RED_CNT_W'(RED_STEPS - 1);
      end else if (state_q == F_RED) begin
        red_cnt_q <= red_cnt_q - 1'b1;
        if (red_cnt_q == '0) yaw_q <= ANG_W'(red_val) - HALF_A;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q <= delta_x_i;
      dy_q <= delta_y_i;
    end
    if (state_q == F_MUL) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
    end
    if (state_q == F_SUM) begin
      u_q <= RED_W'(yaw_sum);
    end else if (state_q == F_RED) begin
      u_q <= red_val;
    end
  end

endmodule

FILE: rtl/yawpc_queue.sv
// Two-entry queue of angle pairs between the front end and the vector unit.
// Uses yawpc_pkg for the entry type and depth.
`timescale 1ns / 1ps

module yawpc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  yawpc_pkg::angles_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output yawpc_pkg::angles_t head_o,
  output logic               empty_o
);
  import yawpc_pkg::*;

  angles_t mem_q [Q_DEPTH];

  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o  = (count_q == (QPTR_W+1)'(Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

FILE: rtl/yawpc_cordic.sv
// Iterative rotation-mode CORDIC: sine and cosine in Q2.30, one step per cycle.
// Uses yawpc_pkg for the arctangent table and gain constant.
`timescale 1ns / 1ps

module yawpc_cordic #(
  parameter int STEPS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [yawpc_pkg::ANG_W-1:0]   angle_i,
  output logic                                 done_o,
  output logic signed [yawpc_pkg::Q30_W-1:0]   sin_o,
  output logic signed [yawpc_pkg::Q30_W-1:0]   cos_o
);
  import yawpc_pkg::*;

  localparam int N = (STEPS > ATAN_N) ? ATAN_N : STEPS;
  localparam logic signed [Z_W-1:0] QUARTER_Z = Z_W'(QUARTER_TURN);
  localparam logic signed [Z_W-1:0] HALF_Z    = Z_W'(YAW_HALF);

  logic busy_q, done_q, flip_q;
  logic [ATAN_IDX_W-1:0] i_q;
  logic signed [Q30_W-1:0] x_q, y_q, xs, ys;
  logic signed [Z_W-1:0] z_q, ang, z0, atan_z;
  logic flip0, last;

  assign ang = $signed({{(Z_W-ANG_W){angle_i[ANG_W-1]}}, angle_i});

  always_comb begin
    z0    = ang;
    flip0 = 1'b0;
    if (ang > QUARTER_Z) begin
      z0    = ang - HALF_Z;
      flip0 = 1'b1;
    end else if (ang < -QUARTER_Z) begin
      z0    = ang + HALF_Z;
      flip0 = 1'b1;
    end
  end

  assign xs     = x_q >>> i_q;
  assign ys     = y_q >>> i_q;
  assign atan_z = $signed(Z_W'(atan_deg(i_q)));
  assign last   = (i_q == ATAN_IDX_W'(N - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 1'b1;
        if (last) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= Q30_W'(GAIN_Q30);
      y_q    <= '0;
      z_q    <= z0;
      flip_q <= flip0;
    end else if (busy_q) begin
      if (!z_q[Z_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_z;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_z;
      end
    end
  end

  assign done_o = done_q;
  assign sin_o  = flip_q ? -y_q : y_q;
  assign cos_o  = flip_q ? -x_q : x_q;

endmodule

FILE: rtl/yawpc_back.sv
// Back end: pops angle pairs, runs two CORDICs, forms the basis vectors with one
// shared multiplier and holds the result word for the output. Uses yawpc_pkg, yawpc_cordic.
`timescale 1ns / 1ps

module yawpc_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  output logic               pop_o,
  input  yawpc_pkg::angles_t head_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output yawpc_pkg::result_t result_o
);
  import yawpc_pkg::*;

  back_state_e state_q, state_d;

  angles_t item_q;
  logic [MUL_CNT_W-1:0] mul_cnt_q;
  logic signed [63:0] prod_q, prod_d;
  logic signed [Q30_W-1:0] mul_a, mul_b;
  logic signed [COMP_W-1:0] res_q [MUL_N];
  logic [1:0] res_idx;
  result_t out_q;
  logic out_valid_q, out_free, load, pop;

  logic done_y, done_p;
  logic signed [Q30_W-1:0] sy, cy, sp, cp;

  yawpc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pop),
    .angle_i (head_i.yaw),
    .done_o  (done_y),
    .sin_o   (sy),
    .cos_o   (cy)
  );

  yawpc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pop),
    .angle_i ($signed({head_i.pitch[PITCH_W-1], head_i.pitch})),
    .done_o  (done_p),
    .sin_o   (sp),
    .cos_o   (cp)
  );

  always_comb begin
    case (mul_cnt_q)
      3'd0:    begin mul_a = cy;  mul_b = cp; end
      3'd1:    begin mul_a = sy;  mul_b = cp; end
      3'd2:    begin mul_a = -cy; mul_b = sp; end
      3'd3:    begin mul_a = -sy; mul_b = sp; end
      default: begin mul_a = '0;  mul_b = '0; end
    endcase
  end

  assign prod_d  = mul_a * mul_b;
  assign res_idx = 2'(mul_cnt_q - 1'b1);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (!empty_i) state_d = B_ROT;
      B_ROT:   if (done_y && done_p) state_d = B_MUL;
      B_MUL:   if (mul_cnt_q == MUL_CNT_W'(MUL_N)) state_d = B_OUT;
      B_OUT:   if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    unique case (state_q)
      B_IDLE:  pop = !empty_i;
      B_OUT:   load = out_free;
      default: ;
    endcase
  end

  assign pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      mul_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_ROT) begin
        mul_cnt_q <= '0;
      end else if (state_q == B_MUL) begin
        mul_cnt_q <= mul_cnt_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) item_q <= head_i;
    if (state_q == B_MUL) begin
      if (mul_cnt_q != MUL_CNT_W'(MUL_N)) prod_q <= prod_d;
      if (mul_cnt_q != '0) res_q[res_idx] <= prod_to_q15(prod_q);
    end
    if (load) begin
      out_q.yaw_angle   <= item_q.yaw;
      out_q.pitch_angle <= item_q.pitch;
      out_q.view_x      <= res_q[0];
      out_q.view_y      <= q30_to_q15(sp);
      out_q.view_z      <= res_q[1];
      out_q.right_x     <= q30_to_q15(-sy);
      out_q.right_y     <= '0;
      out_q.right_z     <= q30_to_q15(cy);
      out_q.up_x        <= res_q[2];
      out_q.up_y        <= q30_to_q15(cp);
      out_q.up_z        <= res_q[3];
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

FILE: rtl/yaw_pitch_camera_orientation.sv
// Top level of the yaw/pitch camera orientation block.
// Uses yawpc_pkg, yawpc_front, yawpc_queue, yawpc_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one mouse word: delta_x, delta_y.
//   Output channel (out_valid_o / out_stall_i) gives one word per input: yaw and
//   pitch in 1/65536 degree, then view, right and up vectors in Q1.15.
//   Config channel (cfg_valid_i / cfg_ready_o) writes look_sensitivity; always ready.
//   Write it only while no word is in flight.
// Processing:
//   The front end works on one word at a time: multiply, sum, 9 wrap steps, push.
//   The back end works on one word at a time, through the two iterative
//   CORDICs and the shared 32x32 multiplier (4 products).
//   The front end can take a new word while the back end works on earlier ones.
// Reset: yaw -90 degrees, pitch 0, sensitivity 6554, queue and output empty.
// Stall: a stalled output word holds; the back end finishes the next word and
//   waits, the two-entry queue fills, then the front end stalls the input.
`timescale 1ns / 1ps

module yaw_pitch_camera_orientation #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [yawpc_pkg::SENS_W-1:0]           cfg_look_sensitivity_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [yawpc_pkg::DELTA_W-1:0]   delta_x_i,
  input  logic signed [yawpc_pkg::DELTA_W-1:0]   delta_y_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [yawpc_pkg::ANG_W-1:0]     yaw_angle_o,
  output logic signed [yawpc_pkg::PITCH_W-1:0]   pitch_angle_o,
  output logic signed [yawpc_pkg::COMP_W-1:0]    view_x_o,
  output logic signed [yawpc_pkg::COMP_W-1:0]    view_y_o,
  output logic signed [yawpc_pkg::COMP_W-1:0]    view_z_o,
  output logic signed [yawpc_pkg::COMP_W-1:0]    right_x_o,
  output logic signed [yawpc_pkg::COMP_W-1:0]    right_y_o,
  output logic signed [yawpc_pkg::COMP_W-1:0]    right_z_o,
  output logic signed [yawpc_pkg::COMP_W-1:0]    up_x_o,
  output logic signed [yawpc_pkg::COMP_W-1:0]    up_y_o,
  output logic signed [yawpc_pkg::COMP_W-1:0]    up_z_o
);
  import yawpc_pkg::*;

  logic [SENS_W-1:0] sens_q;
  logic push, full, pop, empty;
  angles_t push_data, head;
  result_t result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q <= SENS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sens_q <= cfg_look_sensitivity_i;
    end
  end

  yawpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .delta_x_i   (delta_x_i),
    .delta_y_i   (delta_y_i),
    .sens_i      (sens_q),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  yawpc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  yawpc_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .head_i      (head),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign yaw_angle_o   = result.yaw_angle;
  assign pitch_angle_o = result.pitch_angle;
  assign view_x_o      = result.view_x;
  assign view_y_o      = result.view_y;
  assign view_z_o      = result.view_z;
  assign right_x_o     = result.right_x;
  assign right_y_o     = result.right_y;
  assign right_z_o     = result.right_z;
  assign up_x_o        = result.up_x;
  assign up_y_o        = result.up_y;
  assign up_z_o        = result.up_z;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the yaw/pitch camera orientation block.
// It needs only yawpc_pkg and the block's RTL. A class-based scoreboard predicts each output word.
`timescale 1ns / 1ps

module testbench;
  import yawpc_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 150;

  // atan(2^-i) in 1/65536 degree
  localparam longint ATAN_UNITS [0:29] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0
  };

  class camera_scoreboard;
    longint  yaw_acc;
    longint  pitch_acc;
    longint  sens;
    result_t pending_q[$];
    int      errors;
    int      words_seen;

    function new();
      yaw_acc    = -QUARTER_TURN;
      pitch_acc  = 0;
      sens       = SENS_RESET;
      errors     = 0;
      words_seen = 0;
    endfunction

    function void sin_cos(input longint angle, output longint s, output longint c);
      longint x, y, z, xs, ys;
      bit     flip;
      int     n;
      x    = GAIN_Q30;
      y    = 0;
      z    = angle;
      flip = 1'b0;
      if (z > QUARTER_TURN) begin
        z -= YAW_HALF;
        flip = 1'b1;
      end else if (z < -QUARTER_TURN) begin
        z += YAW_HALF;
        flip = 1'b1;
      end
      n = (CORDIC_STEPS > ATAN_N) ? ATAN_N : CORDIC_STEPS;
      for (int i = 0; i < n; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys;
          y += xs;
          z -= ATAN_UNITS[i];
        end else begin
          x += ys;
          y -= xs;
          z += ATAN_UNITS[i];
        end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function longint sat_q15(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint trig_q15(longint v);
      return sat_q15((v + (longint'(1) <<< 14)) >>> 15);
    endfunction

    function longint mul_q15(longint a, longint b);
      return sat_q15((a * b + (longint'(1) <<< 44)) >>> 45);
    endfunction

    // advance the camera angles by one mouse word and queue the expected output
    function void note_deltas(logic signed [DELTA_W-1:0] dx, logic signed [DELTA_W-1:0] dy);
      longint  t, sy, cy, sp, cp;
      result_t e;
      t = yaw_acc + longint'(dx) * sens + YAW_HALF;
      t = t % YAW_TURN;
      if (t < 0) t += YAW_TURN;
      yaw_acc = t - YAW_HALF;
      t = pitch_acc + longint'(dy) * sens;
      if (t > PITCH_LIMIT) t = PITCH_LIMIT;
      if (t < -PITCH_LIMIT) t = -PITCH_LIMIT;
      pitch_acc = t;
      sin_cos(yaw_acc, sy, cy);
      sin_cos(pitch_acc, sp, cp);
      e.yaw_angle   = ANG_W'(yaw_acc);
      e.pitch_angle = PITCH_W'(pitch_acc);
      e.view_x      = COMP_W'(mul_q15(cy, cp));
      e.view_y      = COMP_W'(trig_q15(sp));
      e.view_z      = COMP_W'(mul_q15(sy, cp));
      e.right_x     = COMP_W'(trig_q15(-sy));
      e.right_y     = '0;
      e.right_z     = COMP_W'(trig_q15(cy));
      e.up_x        = COMP_W'(mul_q15(-cy, sp));
      e.up_y        = COMP_W'(trig_q15(cp));
      e.up_z        = COMP_W'(mul_q15(-sy, sp));
      pending_q.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch %0d at word %0d, %s: got %0d, expected %0d",
               errors, words_seen, what, got, want);
    endtask

    task check_word(result_t got);
      result_t e;
      words_seen++;
      if (pending_q.size() == 0) begin
        report("word with nothing pending", got.yaw_angle, 0);
        return;
      end
      e = pending_q.pop_front();
      if (got.yaw_angle !== e.yaw_angle) report("yaw_angle", got.yaw_angle, e.yaw_angle);
      if (got.pitch_angle !== e.pitch_angle)
        report("pitch_angle", got.pitch_angle, e.pitch_angle);
      if (got.view_x !== e.view_x) report("view_x", got.view_x, e.view_x);
      if (got.view_y !== e.view_y) report("view_y", got.view_y, e.view_y);
      if (got.view_z !== e.view_z) report("view_z", got.view_z, e.view_z);
      if (got.right_x !== e.right_x) report("right_x", got.right_x, e.right_x);
      if (got.right_y !== e.right_y) report("right_y", got.right_y, e.right_y);
      if (got.right_z !== e.right_z) report("right_z", got.right_z, e.right_z);
      if (got.up_x !== e.up_x) report("up_x", got.up_x, e.up_x);
      if (got.up_y !== e.up_y) report("up_y", got.up_y, e.up_y);
      if (got.up_z !== e.up_z) report("up_z", got.up_z, e.up_z);
    endtask
  endclass

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [SENS_W-1:0]         cfg_sens  = '0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic signed [DELTA_W-1:0] dx        = '0;
  logic signed [DELTA_W-1:0] dy        = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [ANG_W-1:0]   yaw_angle;
  logic signed [PITCH_W-1:0] pitch_angle;
  logic signed [COMP_W-1:0]  view_x, view_y, view_z;
  logic signed [COMP_W-1:0]  right_x, right_y, right_z;
  logic signed [COMP_W-1:0]  up_x, up_y, up_z;
  result_t                   out_word;

  camera_scoreboard sb;
  bit  calm        = 1'b0;
  bit  hold_done   = 1'b0;
  int  hold_left   = 0;
  int  n_sent      = 0;
  int  idle_cycles = 0;

  assign out_word = {yaw_angle, pitch_angle, view_x, view_y, view_z,
                     right_x, right_y, right_z, up_x, up_y, up_z};

  yaw_pitch_camera_orientation #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) DUT (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_look_sensitivity_i(cfg_sens),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .delta_x_i             (dx),
    .delta_y_i             (dy),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .yaw_angle_o           (yaw_angle),
    .pitch_angle_o         (pitch_angle),
    .view_x_o              (view_x),
    .view_y_o              (view_y),
    .view_z_o              (view_z),
    .right_x_o             (right_x),
    .right_y_o             (right_y),
    .right_z_o             (right_z),
    .up_x_o                (up_x),
    .up_y_o                (up_y),
    .up_z_o                (up_z)
  );

  always #4 clk = ~clk;

  // output side: check accepted words, random stalls, one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_word(out_word);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && n_sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 25);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task send_deltas(input logic signed [DELTA_W-1:0] x, input logic signed [DELTA_W-1:0] y);
    while (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    dx       <= x;
    dy       <= y;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_deltas(x, y);
    n_sent++;
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task set_sensitivity(input logic [SENS_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_sens  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.sens = v;
  endtask

  function automatic logic signed [DELTA_W-1:0] pick_delta();
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: v = int'($urandom_range(128)) - 64;
      6, 7:             v = int'($urandom);
      8: begin
        case ($urandom_range(3))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = -1;
          default: v = 0;
        endcase
      end
      default:          v = int'($urandom_range(4096)) - 2048;
    endcase
    return DELTA_W'(v);
  endfunction

  initial begin
    logic [SENS_W-1:0] s;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_deltas(0, 0);
    drain();

    // half a degree per count: walk through the quadrant and wrap boundaries
    set_sensitivity(16'd32768);
    send_deltas(180, 0);
    send_deltas(180, 178);
    send_deltas(1, 1);
    send_deltas(179, -356);
    send_deltas(-1, -1);
    send_deltas(-359, 178);
    send_deltas(-180, 0);
    send_deltas(-1, 0);
    drain();

    set_sensitivity(16'hFFFF);
    send_deltas(32767, 32767);
    send_deltas(-32768, -32768);
    send_deltas(32767, -32768);
    send_deltas(-32768, 32767);
    drain();

    set_sensitivity(16'd0);
    send_deltas(12345, -23456);
    send_deltas(-1, 1);
    drain();

    set_sensitivity(16'd6554);
    send_deltas(1, -1);
    send_deltas(-1, 1);
    send_deltas(32767, 0);

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0:       s = 16'hFFFF;
        1:       s = SENS_W'($urandom_range(65534, 1));
        2:       s = SENS_W'($urandom_range(200, 1));
        3:       s = 16'd0;
        4:       s = SENS_W'($urandom_range(65535));
        default: s = 16'd32768;
      endcase
      set_sensitivity(s);
      calm = (p == 1);
      for (int k = 0; k < ((p == 3) ? 30 : 250); k++)
        send_deltas(pick_delta(), pick_delta());
    end
    calm = 1'b0;
    drain();
    repeat (60) @(posedge clk);

    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
